>>> hdl/sstf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SSTF scheduler package
// Sizes, result codes, register indexes and the cell types shared by the
// interfaces, the slot cell and the scheduler top level.
// ----------------------------------------------------------------------------
package sstf_pkg;

	localparam int MAX_REQUESTERS = 16;
	localparam int TRACK_BITS     = 16;

	// Fixed field widths of the channels and the register port.
	localparam int REQ_W     = 4;
	localparam int TRK_W     = 16;
	localparam int KIND_W    = 2;
	localparam int CFG_W     = 5;
	localparam int CFG_IDX_W = 1;

	localparam int IDX_W    = $clog2(MAX_REQUESTERS);
	localparam int CNT_W    = $clog2(MAX_REQUESTERS + 1);
	// The scan refreshes the distances, then steps through each cell of the chain.
	localparam int SCAN_LEN = MAX_REQUESTERS + 1;
	localparam int SCAN_W   = $clog2(SCAN_LEN + 1);

	typedef enum logic [KIND_W-1:0] {
		KIND_ACCEPT = 2'd0,
		KIND_REFUSE = 2'd1,
		KIND_SERVE  = 2'd2
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_QUEUE_CAPACITY    = 1'b0,
		REG_ACTIVE_REQUESTERS = 1'b1
	} reg_idx_t;

	typedef logic [TRACK_BITS-1:0] track_t;

	// Best candidate seen so far, handed from cell to cell.
	typedef struct packed {
		logic             valid;
		logic [IDX_W-1:0] idx;
		track_t           gap;
		track_t           trk;
		logic             fin;
	} cand_t;

	// Write and clear command for one slot cell.
	typedef struct packed {
		logic   wr;
		logic   clr;
		track_t trk;
		logic   fin;
	} cell_cmd_t;

endpackage

>>> hdl/sstf_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SSTF scheduler channels
// Valid/ready channels for incoming track requests and outgoing results.
// ----------------------------------------------------------------------------
interface sstf_req_if;
	import sstf_pkg::*;

	logic             valid;
	logic             ready;
	logic [REQ_W-1:0] requester;
	logic [TRK_W-1:0] track;
	logic             last_request;

	modport source (output valid, output requester, output track, output last_request,
		input ready);
	modport sink (input valid, input requester, input track, input last_request,
		output ready);
endinterface

interface sstf_res_if;
	import sstf_pkg::*;

	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [REQ_W-1:0]  served_requester;
	logic [TRK_W-1:0]  served_track;
	logic              last_of_run;

	modport source (output valid, output kind, output served_requester, output served_track,
		output last_of_run, input ready);
	modport sink (input valid, input kind, input served_requester, input served_track,
		input last_of_run, output ready);
endinterface

>>> hdl/sstf_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SSTF slot cell
// Holds one requester's pending request, keeps its seek distance to the head
// and passes the nearer of its own request and the incoming candidate on.
// ----------------------------------------------------------------------------
module sstf_cell (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [sstf_pkg::IDX_W-1:0]   cell_idx,
	input  sstf_pkg::track_t             head,
	input  sstf_pkg::cell_cmd_t          cmd,
	input  sstf_pkg::cand_t              cand_in,
	output sstf_pkg::cand_t              cand_out,
	output logic                         pending
);
	import sstf_pkg::*;

	logic   pending_q;
	track_t track_q;
	logic   fin_q;
	track_t dist_q;
	cand_t  cand_q;
	cand_t  own;
	logic   take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 1'b0;
		end else if (cmd.wr) begin
			pending_q <= 1'b1;
		end else if (cmd.clr) begin
			pending_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			track_q <= cmd.trk;
			fin_q   <= cmd.fin;
		end
		dist_q <= (track_q >= head) ? track_q - head : head - track_q;
	end

	always_comb begin
		own.valid = 1'b1;
		own.idx   = cell_idx;
		own.gap   = dist_q;
		own.trk   = track_q;
		own.fin   = fin_q;
	end

	// Strictly nearer only, so a tie keeps the lower requester from upstream.
	assign take = pending_q && (!cand_in.valid || dist_q < cand_in.gap);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_q <= '0;
		end else begin
			cand_q <= take ? own : cand_in;
		end
	end

	assign cand_out = cand_q;
	assign pending  = pending_q;

endmodule

>>> hdl/sstf_request_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SSTF request scheduler
// Shortest-seek-time-first scheduler over a chain of per-requester slot cells.
// ----------------------------------------------------------------------------
// Requests arrive on req (requester, track, last_request); every request gives
// one result on res: accepted, refused (retry later) or, after an accept that
// fills the queue to its limit, one or more serviced results. The last result
// of each request carries last_of_run. The queue limit is the smaller of the
// queue capacity register and the live active count; writing the active
// requesters register reloads that count. Write registers only while idle.
// A refused or accepted result is registered and appears on res in the cycle
// after the request is taken. Each service needs a scan of the cell chain: the
// seek distances are refreshed, then the nearest candidate passes through every
// cell in turn. A new request is taken only when the block is idle and the
// result register is free. When the receiver stalls, the finished result is
// held and the block waits. Reset clears all pending slots, the head position,
// the counts, and sets the capacity to one with no active requesters.
// ----------------------------------------------------------------------------
module sstf_request_scheduler (
	input  logic                           clk,
	input  logic                           arst_n,
	sstf_req_if.sink                       req,
	sstf_res_if.source                     res,
	input  logic                           cfg_we,
	input  logic [sstf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sstf_pkg::CFG_W-1:0]     cfg_data
);
	import sstf_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_SCAN = 2'b10
	} state_t;

	state_t              state_q;
	logic [CFG_W-1:0]    cap_q;
	logic [CFG_W-1:0]    live_q;
	logic [CNT_W-1:0]    pend_cnt_q;
	track_t              head_q;
	logic [SCAN_W-1:0]   scan_cnt_q;

	logic                out_valid_q;
	kind_t               out_kind_q;
	logic [REQ_W-1:0]    out_req_q;
	logic [TRK_W-1:0]    out_trk_q;
	logic                out_last_q;

	cand_t               chain [MAX_REQUESTERS+1];
	cell_cmd_t           cmd [MAX_REQUESTERS];
	logic [MAX_REQUESTERS-1:0] pend_vec;
	logic [MAX_REQUESTERS-1:0] sel_vec;

	logic                out_free;
	logic                in_fire;
	logic                in_range;
	logic                hit;
	logic                refuse;
	logic [CFG_W-1:0]    lim;
	logic [CNT_W-1:0]    pend_inc;
	logic                acc_cont;
	logic                scan_done;
	logic                serve_fire;
	cand_t               best;
	logic [CNT_W-1:0]    pend_dec;
	logic [CFG_W-1:0]    live_next;
	logic [CFG_W-1:0]    lim_next;
	logic                srv_cont;
	track_t              in_trk;

	assign chain[0] = '0;
	assign in_trk   = req.track[TRACK_BITS-1:0];

	for (genvar i = 0; i < MAX_REQUESTERS; i++) begin : g_cell
		assign sel_vec[i]  = (int'(req.requester) == i);
		assign cmd[i].wr   = in_fire && !refuse && sel_vec[i];
		assign cmd[i].clr  = serve_fire && (best.idx == IDX_W'(i));
		assign cmd[i].trk  = in_trk;
		assign cmd[i].fin  = req.last_request;

		sstf_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cell_idx (IDX_W'(i)),
			.head     (head_q),
			.cmd      (cmd[i]),
			.cand_in  (chain[i]),
			.cand_out (chain[i+1]),
			.pending  (pend_vec[i])
		);
	end

	assign best = chain[MAX_REQUESTERS];

	assign out_free = !out_valid_q || res.ready;
	assign req.ready = (state_q == ST_IDLE) && out_free;
	assign in_fire  = req.valid && req.ready;

	assign lim      = (live_q < cap_q) ? live_q : cap_q;
	assign in_range = int'(req.requester) < MAX_REQUESTERS;
	assign hit      = |(pend_vec & sel_vec);
	assign refuse   = !in_range || (int'(pend_cnt_q) >= int'(lim)) || hit;
	assign pend_inc = pend_cnt_q + CNT_W'(1);
	assign acc_cont = int'(pend_inc) >= int'(lim);

	assign scan_done  = (int'(scan_cnt_q) == SCAN_LEN);
	assign serve_fire = (state_q == ST_SCAN) && scan_done && out_free;
	assign pend_dec   = pend_cnt_q - CNT_W'(1);
	assign live_next  = (best.fin && live_q != '0) ? live_q - CFG_W'(1) : live_q;
	assign lim_next   = (live_next < cap_q) ? live_next : cap_q;
	assign srv_cont   = (pend_dec != '0) && (int'(pend_dec) >= int'(lim_next));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cap_q      <= CFG_W'(1);
			live_q     <= '0;
			pend_cnt_q <= '0;
			head_q     <= '0;
			scan_cnt_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_QUEUE_CAPACITY:    cap_q  <= cfg_data;
					REG_ACTIVE_REQUESTERS: live_q <= cfg_data;
					default: ;
				endcase
			end
			unique case (state_q)
				ST_IDLE: begin
					scan_cnt_q <= '0;
					if (in_fire && !refuse) begin
						pend_cnt_q <= pend_inc;
						if (acc_cont) begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (serve_fire) begin
						head_q     <= best.trk;
						live_q     <= live_next;
						pend_cnt_q <= pend_dec;
						scan_cnt_q <= '0;
						if (!srv_cont) begin
							state_q <= ST_IDLE;
						end
					end else if (!scan_done) begin
						scan_cnt_q <= scan_cnt_q + SCAN_W'(1);
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Result register: one transaction at a time toward the receiver.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire || serve_fire) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			out_kind_q <= refuse ? KIND_REFUSE : KIND_ACCEPT;
			out_req_q  <= req.requester;
			out_trk_q  <= TRK_W'(in_trk);
			out_last_q <= refuse || !acc_cont;
		end else if (serve_fire) begin
			out_kind_q <= KIND_SERVE;
			out_req_q  <= REQ_W'(best.idx);
			out_trk_q  <= TRK_W'(best.trk);
			out_last_q <= !srv_cont;
		end
	end

	assign res.valid            = out_valid_q;
	assign res.kind             = out_kind_q;
	assign res.served_requester = out_req_q;
	assign res.served_track     = out_trk_q;
	assign res.last_of_run      = out_last_q;

`ifndef SYNTHESIS
	// The pending count always matches the cells that hold a request.
	a_count_matches: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(pend_vec) == int'(pend_cnt_q))
		else $error("pending count differs from pending cells");

	// A finished scan always finds a pending request.
	a_scan_finds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && scan_done) |-> best.valid)
		else $error("scan ended without a candidate");

	// A refused request leaves the queue untouched and the block idle.
	a_refuse_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && refuse) |=> (state_q == ST_IDLE && $stable(pend_cnt_q)))
		else $error("refused request changed the queue");

	// An accepted request grows the queue by one.
	a_accept_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && !refuse) |=> (pend_cnt_q == $past(pend_inc)))
		else $error("accepted request not counted");
`endif

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SSTF request scheduler testbench
// Drives track requests through the request channel and checks each result
// against a cycle-free prediction of the shortest-seek-time-first queue.
// Directed requests cover refusals, tie breaks and a lowered queue limit.
// Random phases then run under a range of capacity and requester settings.
// Both channels idle at random.
// ----------------------------------------------------------------------------
module tb;
	import sstf_pkg::*;

	localparam int CYCLE_LIMIT   = 2000000;
	localparam int PHASE_ITEMS   = 25;
	localparam int PHASE_COUNT   = 16;
	localparam int SETTLE_CYCLES = 4;
	localparam int DRAIN_CYCLES  = 40;

	typedef struct packed {
		kind_t             kind;
		logic [REQ_W-1:0]  who;
		logic [TRK_W-1:0]  trk;
		logic              last;
	} sched_result_t;

	class seek_board;
		bit                  pending[MAX_REQUESTERS];
		logic [TRK_W-1:0]    slot_trk[MAX_REQUESTERS];
		bit                  slot_fin[MAX_REQUESTERS];
		logic [TRK_W-1:0]    head;
		int                  live_active;
		int                  capacity;
		int                  pending_count;
		sched_result_t       due_results[$];
		int                  mismatches;
		int                  n_requests;
		int                  n_accepted;
		int                  n_refused;
		int                  n_served;
		int                  n_settings;

		function new();
			head = '0;
			live_active = 0;
			capacity = 1;
			pending_count = 0;
			mismatches = 0;
			n_requests = 0;
			n_accepted = 0;
			n_refused = 0;
			n_served = 0;
			n_settings = 0;
			foreach (pending[i]) pending[i] = 0;
		endfunction

		function void set_reg(reg_idx_t idx, int value);
			if (idx == REG_QUEUE_CAPACITY)
				capacity = value & 31;
			else
				live_active = value & 31;
			n_settings++;
		endfunction

		function int fill_limit();
			return (live_active < capacity) ? live_active : capacity;
		endfunction

		// Works out every result that one request causes, refused or accepted.
		function void take_request(logic [REQ_W-1:0] who, logic [TRK_W-1:0] trk, logic fin);
			sched_result_t batch[$];
			sched_result_t r;
			int best;
			int best_dist;
			int d;
			n_requests++;
			if (pending_count >= fill_limit() || pending[who]) begin
				r = '{KIND_REFUSE, who, trk, 1'b1};
				due_results.insert(due_results.size(), r);
				return;
			end
			pending[who] = 1;
			slot_trk[who] = trk;
			slot_fin[who] = fin;
			pending_count++;
			r = '{KIND_ACCEPT, who, trk, 1'b0};
			batch.insert(batch.size(), r);
			while (pending_count > 0 && pending_count >= fill_limit()) begin
				best = -1;
				best_dist = 0;
				for (int i = 0; i < MAX_REQUESTERS; i++) begin
					if (pending[i]) begin
						d = int'(slot_trk[i]) - int'(head);
						if (d < 0) d = -d;
						if (best < 0 || d < best_dist) begin
							best = i;
							best_dist = d;
						end
					end
				end
				if (best < 0) begin
					pending_count = 0;
					break;
				end
				r = '{KIND_SERVE, REQ_W'(best), slot_trk[best], 1'b0};
				batch.insert(batch.size(), r);
				head = slot_trk[best];
				if (slot_fin[best] && live_active > 0) live_active--;
				pending[best] = 0;
				pending_count--;
			end
			batch[batch.size()-1].last = 1'b1;
			foreach (batch[i]) due_results.insert(due_results.size(), batch[i]);
		endfunction

		function void report(string what, sched_result_t exp, sched_result_t got);
			mismatches++;
			if (mismatches <= 10) begin
				$display("[%0t] %s: expected kind %0d req %0d track %h last %0b",
					$time, what, exp.kind, exp.who, exp.trk, exp.last);
				$display("    got kind %0d req %0d track %h last %0b",
					got.kind, got.who, got.trk, got.last);
			end
		endfunction

		function void check_result(sched_result_t got);
			sched_result_t exp;
			case (got.kind)
				KIND_ACCEPT: n_accepted++;
				KIND_REFUSE: n_refused++;
				default:     n_served++;
			endcase
			if (due_results.size() == 0) begin
				report("unexpected result", '0, got);
				return;
			end
			exp = due_results.pop_front();
			if (got.kind != exp.kind || got.who != exp.who || got.trk != exp.trk ||
				got.last != exp.last)
				report("result mismatch", exp, got);
		endfunction

		function int outstanding();
			return due_results.size();
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;
	bit                   steady = 1'b0;
	int                   cycle_count = 0;
	seek_board            board;

	sstf_req_if req_ch ();
	sstf_res_if res_ch ();

	sstf_request_scheduler uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.res       (res_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles", cycle_count);
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Result receiver: random back-pressure except during the steady stretch.
	always @(posedge clk) begin
		res_ch.ready <= steady || ($urandom_range(99) >= 18);
	end

	always @(posedge clk) begin
		sched_result_t got;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			got = '{kind_t'(res_ch.kind), res_ch.served_requester, res_ch.served_track,
				res_ch.last_of_run};
			board.check_result(got);
		end
	end

	// Presents one request and returns at the edge where it is taken.
	// The valid line is left high so that the next request may follow at once.
	task automatic drive_request(logic [REQ_W-1:0] who, logic [TRK_W-1:0] trk, logic fin);
		while (!steady && $urandom_range(99) < 18) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.requester <= who;
		req_ch.track <= trk;
		req_ch.last_request <= fin;
		do @(posedge clk); while (!req_ch.ready);
		board.take_request(who, trk, fin);
	endtask

	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (board.outstanding() != 0) @(posedge clk);
	endtask

	// Registers change only once the block has gone quiet.
	task automatic write_reg(reg_idx_t idx, int value);
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_W'(value);
		@(posedge clk);
		board.set_reg(idx, value);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [REQ_W-1:0] pick_requester();
		int open_slots[$];
		for (int i = 0; i < MAX_REQUESTERS; i++)
			if (!board.pending[i]) open_slots.insert(open_slots.size(), i);
		if (open_slots.size() != 0 && $urandom_range(3) != 0)
			return REQ_W'(open_slots[$urandom_range(open_slots.size() - 1)]);
		return REQ_W'($urandom_range(MAX_REQUESTERS - 1));
	endfunction

	function automatic logic [TRK_W-1:0] pick_track();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			2: return board.head + TRK_W'($urandom_range(8));
			3: return board.head - TRK_W'($urandom_range(8));
			default: return TRK_W'($urandom);
		endcase
	endfunction

	initial begin
		int caps[PHASE_COUNT];
		int acts[PHASE_COUNT];
		board = new();
		req_ch.valid = 1'b0;
		req_ch.requester = '0;
		req_ch.track = '0;
		req_ch.last_request = 1'b0;
		res_ch.ready = 1'b0;
		caps = '{1, 16, 4, 31, 8, 5, 2, 16, 0, 16, 0, 0, 0, 0, 0, 31};
		acts = '{16, 16, 8, 6, 3, 31, 2, 1, 16, 0, 0, 0, 0, 0, 0, 31};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// With the reset settings no requester is active, so the request is refused.
		drive_request(4'd5, 16'h1234, 1'b0);
		write_reg(REG_QUEUE_CAPACITY, 0);
		write_reg(REG_ACTIVE_REQUESTERS, 4);
		drive_request(4'd0, 16'h0000, 1'b1);

		// Three requests fill the queue; a repeat from a pending requester is refused.
		write_reg(REG_QUEUE_CAPACITY, 16);
		write_reg(REG_ACTIVE_REQUESTERS, 3);
		drive_request(4'd0, 16'hFFFF, 1'b0);
		drive_request(4'd15, 16'h0000, 1'b1);
		drive_request(4'd0, 16'h0001, 1'b0);
		drive_request(4'd7, 16'h8000, 1'b1);

		// Equal seek distances go to the lower requester.
		write_reg(REG_QUEUE_CAPACITY, 2);
		write_reg(REG_ACTIVE_REQUESTERS, 2);
		drive_request(4'd5, 16'h8000, 1'b0);
		drive_request(4'd4, 16'h8000, 1'b0);
		drive_request(4'd9, 16'h8010, 1'b0);
		drive_request(4'd3, 16'h7FF0, 1'b0);

		// Lowering the limit under the pending count gets the next requests refused,
		// and the pending entries stay queued while the active count holds at one.
		write_reg(REG_QUEUE_CAPACITY, 4);
		write_reg(REG_ACTIVE_REQUESTERS, 4);
		drive_request(4'd1, 16'h0100, 1'b1);
		drive_request(4'd2, 16'h0200, 1'b1);
		write_reg(REG_ACTIVE_REQUESTERS, 1);
		drive_request(4'd6, 16'h0300, 1'b1);
		drive_request(4'd8, 16'h0400, 1'b1);

		for (int p = 0; p < PHASE_COUNT; p++) begin
			if (caps[p] == 0 && acts[p] == 0) begin
				caps[p] = $urandom_range(MAX_REQUESTERS, 1);
				acts[p] = $urandom_range(MAX_REQUESTERS, 1);
			end
			write_reg(REG_QUEUE_CAPACITY, caps[p]);
			write_reg(REG_ACTIVE_REQUESTERS, acts[p]);
			steady = (p >= 6 && p <= 8);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if ($urandom_range(29) == 0) wait_drained();
				drive_request(pick_requester(), pick_track(), $urandom_range(11) == 0);
			end
		end
		steady = 1'b0;

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Ran %0d requests over %0d register writes in %0d cycles.",
			board.n_requests, board.n_settings, cycle_count);
		$display("Results seen: %0d accepted, %0d refused, %0d serviced; %0d mismatches.",
			board.n_accepted, board.n_refused, board.n_served, board.mismatches);
		if (board.mismatches == 0 && board.outstanding() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
